// ===== hw/rtl/ial_pkg.sv =====
// Package for the indexed array list: command and status codes,
// cell control codes and the control struct broadcast along the cell row.
// No dependencies.
package ial_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// Widest index the cell row can ever need (up to 1024 cells).
	localparam int IDX_W = 10;

	localparam int CMD_W = 3;
	localparam int POS_W = 4;
	localparam int CNT_OUT_W = 5;
	localparam int ST_W = 2;

	// Number of positions that the position port can address.
	localparam int TAPS = 1 << POS_W;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Cell operations.
	localparam logic [1:0] KIND_HOLD = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_UP   = 2'd2;
	localparam logic [1:0] KIND_DOWN = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] at;
	} ial_ctrl_t;

endpackage

// ===== hw/rtl/ial_cell.sv =====
// One storage cell of the indexed array list.
// Depends on ial_pkg for the control struct and cell operation codes.
module ial_cell
	import ial_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  ial_ctrl_t        ctrl,
	input  logic [WIDTH-1:0] wr_value,
	input  logic [WIDTH-1:0] lower_data,
	input  logic [WIDTH-1:0] upper_data,
	output logic [WIDTH-1:0] data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WIDTH-1:0] data_q;

	// Up: cells above the point move, the one at it loads; down: cells at or above move.
	always_ff @(posedge clk) begin
		unique case (ctrl.kind)
			KIND_LOAD: begin
				if (MY_IDX == ctrl.at) data_q <= wr_value;
			end
			KIND_UP: begin
				if (MY_IDX > ctrl.at) data_q <= lower_data;
				else if (MY_IDX == ctrl.at) data_q <= wr_value;
			end
			KIND_DOWN: begin
				if (MY_IDX >= ctrl.at) data_q <= upper_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/indexed_array_list.sv =====
// Indexed array list top level: command decode, count register, result
// registers and a row of ial_cell instances. Depends on ial_pkg and ial_cell.
// Usage:
// A command transaction is accepted at a rising clock edge where start is
// high and busy is low. The transaction carries command, position and
// item_value. Busy is tied low and no command stalls, so a new command may
// be issued in every cycle: throughput is one command per clock.
// The result transaction appears in the cycle after acceptance: done is high for
// exactly one clock cycle while read_value, entry_count and status hold the
// result, and the receiver cannot stall.
// Storage is a row of DEPTH cells. Each cell holds one entry and in every
// cycle can keep its word, load the new value, take its lower neighbor's word
// (shift up for push-front and insert) or take its upper neighbor's word
// (shift down for erase). The whole row moves at the same clock edge, which is
// what sets the one-command-per-cycle rate. A read selects one of the first
// sixteen cells by position.
// Reset (arst_n low) clears the entry count and the result strobe. The cell
// contents are not cleared; no command can read an entry beyond the count.
module indexed_array_list
	import ial_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [POS_W-1:0]     position,
	input  logic [WIDTH-1:0]     item_value,
	output logic                 done,
	output logic [WIDTH-1:0]     read_value,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [ST_W-1:0]      status
);

	// Count width holds 0..DEPTH; compare width covers both count and position.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]    count_q;
	logic             done_q;
	logic [WIDTH-1:0] read_value_q;
	logic [ST_W-1:0]  status_q;

	logic             accept;
	logic             full;
	logic             in_range;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] cnt_idx;
	ial_ctrl_t        ctrl;
	logic [ST_W-1:0]  status_d;
	logic [WIDTH-1:0] read_d;
	logic [CW-1:0]    count_d;

	logic [WIDTH-1:0] cell_data [DEPTH];
	logic [WIDTH-1:0] tap       [TAPS];

	// No command stalls the interface, so busy is tied low.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full     = (count_q == FULL_CNT);
	assign in_range = (PW'(position) < PW'(count_q));
	assign pos_idx  = IDX_W'(position);
	assign cnt_idx  = IDX_W'(count_q);

	// Read taps: only the first sixteen cells are addressable by position.
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		if (k < DEPTH) begin : g_live
			assign tap[k] = cell_data[k];
		end else begin : g_none
			assign tap[k] = '0;
		end
	end

	// Command decode: picks the cell operation, the status, the read value and the new count.
	// Errors leave the cells holding and the count unchanged.
	always_comb begin
		ctrl.kind = KIND_HOLD;
		ctrl.at   = pos_idx;
		status_d  = ST_OK;
		read_d    = '0;
		count_d   = count_q;
		unique case (command)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.kind = KIND_LOAD;
					ctrl.at   = cnt_idx;
					count_d   = count_q + CW'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.kind = KIND_UP;
					ctrl.at   = '0;
					count_d   = count_q + CW'(1);
				end
			end
			CMD_INSERT: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.kind = KIND_UP;
					count_d   = count_q + CW'(1);
				end
			end
			CMD_ERASE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.kind = KIND_DOWN;
					count_d   = count_q - CW'(1);
				end
			end
			CMD_READ: begin
				if (!in_range) status_d = ST_RANGE;
				else read_d = tap[position];
			end
			CMD_WRITE: begin
				if (!in_range) status_d = ST_RANGE;
				else ctrl.kind = KIND_LOAD;
			end
			default: begin
				ctrl.kind = KIND_HOLD;
			end
		endcase
		if (!accept) begin
			ctrl.kind = KIND_HOLD;
		end
	end

	// The cell row. The ends see zero from their missing neighbors; those words
	// land only in cells beyond the count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] lower_w;
		logic [WIDTH-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = cell_data[i+1];
		end
		ial_cell #(
			.WIDTH(WIDTH),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.wr_value  (item_value),
			.lower_data(lower_w),
			.upper_data(upper_w),
			.data      (cell_data[i])
		);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_d;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_d;
			status_q     <= status_d;
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = CNT_OUT_W'(count_q);

endmodule
